// ===== hw/rtl/g3bs_pkg.sv =====
// ----------------------------------------------------------------------------
// g3bs_pkg
// Shared types and constants of the 3D grid binomial smoother: payload
// structs, register indexes, controller states and command/status groups.
// ----------------------------------------------------------------------------
package g3bs_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 17;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SIZE_X   = 3'd0,
    CFG_SIZE_Y   = 3'd1,
    CFG_SIZE_Z   = 3'd2,
    CFG_GHOST    = 3'd3,
    CFG_PERIODIC = 3'd4,
    CFG_STRENGTH = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] sample_in;
    logic               is_padding;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               was_filtered;
    logic               grid_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_BL_DIFF,
    ST_BL_MIX,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    LVL_Z,
    LVL_Y,
    LVL_X
  } level_e;

  typedef struct packed {
    logic       accept;
    logic       rd_issue;
    logic       rd_capture;
    logic       bl_diff;
    logic       bl_mix;
    level_e     level;
    logic       out_load;
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic emit_filt;
    logic filt;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/g3bs_ctrl.sv =====
// ----------------------------------------------------------------------------
// g3bs_ctrl
// Sequencer: accepts a request, then walks the 27 stencil reads and the
// three blend levels (z, y, x) before handing the result to the output.
// ----------------------------------------------------------------------------
module g3bs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  g3bs_pkg::dp_sts_t   sts_i,
  output g3bs_pkg::ctrl_cmd_t cmd_o
);
  import g3bs_pkg::*;

  state_e     state_q, state_d;
  level_e     lvl_q, lvl_d;
  logic [1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lvl_q   <= LVL_Z;
      dx_q    <= 2'd0;
      dy_q    <= 2'd0;
      dz_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dz_q    <= dz_d;
    end
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dz_d    = dz_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.emit_req) begin
          state_d = ST_RD_ADDR;
          lvl_d   = LVL_Z;
          dx_d    = sts_i.emit_filt ? 2'd0 : 2'd1;
          dy_d    = sts_i.emit_filt ? 2'd0 : 2'd1;
          dz_d    = sts_i.emit_filt ? 2'd0 : 2'd1;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: begin
        if (!sts_i.filt) begin
          state_d = ST_OUT;
        end else if (dz_q != 2'd2) begin
          dz_d    = dz_q + 2'd1;
          state_d = ST_RD_ADDR;
        end else begin
          dz_d    = 2'd0;
          state_d = ST_BL_DIFF;
        end
      end
      ST_BL_DIFF: state_d = ST_BL_MIX;
      ST_BL_MIX: begin
        unique case (lvl_q)
          LVL_Z: begin
            if (dy_q != 2'd2) begin
              dy_d    = dy_q + 2'd1;
              state_d = ST_RD_ADDR;
            end else begin
              dy_d    = 2'd0;
              lvl_d   = LVL_Y;
              state_d = ST_BL_DIFF;
            end
          end
          LVL_Y: begin
            if (dx_q != 2'd2) begin
              dx_d    = dx_q + 2'd1;
              lvl_d   = LVL_Z;
              state_d = ST_RD_ADDR;
            end else begin
              dx_d    = 2'd0;
              lvl_d   = LVL_X;
              state_d = ST_BL_DIFF;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.rd_issue   = (state_q == ST_RD_ADDR);
    cmd_o.rd_capture = (state_q == ST_RD_DATA);
    cmd_o.bl_diff    = (state_q == ST_BL_DIFF);
    cmd_o.bl_mix     = (state_q == ST_BL_MIX);
    cmd_o.out_load   = (state_q == ST_OUT) && sts_i.out_free;
    cmd_o.level      = lvl_q;
    cmd_o.dx         = dx_q;
    cmd_o.dy         = dy_q;
    cmd_o.dz         = dz_q;
  end

endmodule

// ===== hw/rtl/g3bs_dp.sv =====
// ----------------------------------------------------------------------------
// g3bs_dp
// Datapath: configuration, stream positions, ring store, blend unit and
// the output register.
// ----------------------------------------------------------------------------
module g3bs_dp #(
  parameter int unsigned MAX_Y       = 64,
  parameter int unsigned MAX_Z       = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [g3bs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [g3bs_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  g3bs_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output g3bs_pkg::out_item_t                 out_item_o,
  input  g3bs_pkg::ctrl_cmd_t                 cmd_i,
  output g3bs_pkg::dp_sts_t                   sts_o
);
  import g3bs_pkg::*;

  localparam int unsigned Depth = 2 * MAX_Y * MAX_Z + 4 * MAX_Z;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned OW    = CW + 2;
  localparam int unsigned YW    = $clog2(MAX_Y + 1);
  localparam int unsigned ZW    = $clog2(MAX_Z + 1);
  localparam int unsigned PYW   = $clog2(MAX_Y);
  localparam int unsigned PZW   = $clog2(MAX_Z);
  localparam int unsigned YZW   = $clog2(MAX_Y * MAX_Z + 1);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned DW    = SB + 2;
  localparam int unsigned HW    = DW - 17;
  localparam int unsigned PW    = HW + 18;
  localparam int unsigned RW    = PW + 2;
  localparam logic signed [OW-1:0] DepthS = OW'(Depth);
  localparam logic signed [RW-1:0] SatHi  = RW'({1'b0, {(SB - 1){1'b1}}});
  localparam logic signed [RW-1:0] SatLo  = ~SatHi;

  // configuration
  logic [12:0] size_x_q;
  logic [6:0]  size_y_q, size_z_q;
  logic [2:0]  ghost_q;
  logic        periodic_q;
  logic [16:0] strength_q;
  logic        restart;

  assign restart = cfg_we_i && (cfg_idx_i <= CFG_STRENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q   <= 13'd16;
      size_y_q   <= 7'd16;
      size_z_q   <= 7'd16;
      ghost_q    <= 3'd1;
      periodic_q <= 1'b0;
      strength_q <= 17'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X:   size_x_q   <= cfg_wdata_i[12:0];
        CFG_SIZE_Y:   size_y_q   <= cfg_wdata_i[6:0];
        CFG_SIZE_Z:   size_z_q   <= cfg_wdata_i[6:0];
        CFG_GHOST:    ghost_q    <= cfg_wdata_i[2:0];
        CFG_PERIODIC: periodic_q <= cfg_wdata_i[0];
        CFG_STRENGTH: strength_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [12:0]    eff_x;
  logic [YW-1:0]  eff_y;
  logic [ZW-1:0]  eff_z;
  logic [2:0]     g;
  logic [16:0]    s_eff;
  logic [YZW-1:0] yz;
  logic [CW-1:0]  lag;

  always_comb begin
    if (size_x_q < 13'd5)         eff_x = 13'd5;
    else if (size_x_q > 13'd4096) eff_x = 13'd4096;
    else                          eff_x = size_x_q;
    if (size_y_q < 7'd5)               eff_y = YW'(5);
    else if (32'(size_y_q) > MAX_Y)    eff_y = YW'(MAX_Y);
    else                               eff_y = YW'(size_y_q);
    if (size_z_q < 7'd5)               eff_z = ZW'(5);
    else if (32'(size_z_q) > MAX_Z)    eff_z = ZW'(MAX_Z);
    else                               eff_z = ZW'(size_z_q);
    g     = (ghost_q == 3'd0) ? 3'd1 : ghost_q;
    s_eff = (strength_q > 17'd65536) ? 17'd65536 : strength_q;
    yz    = YZW'(eff_y) * YZW'(eff_z);
    lag   = CW'(yz) + CW'(eff_z) + CW'(1);
  end

  // stream positions and counters
  logic [11:0]    in_x_q, out_x_q;
  logic [PYW-1:0] in_y_q, out_y_q;
  logic [PZW-1:0] in_z_q, out_z_q;
  logic [CW-1:0]  count_q;
  logic [AW-1:0]  wr_ptr_q;
  logic           wr_en;
  logic           in_z_wrap, in_y_wrap, in_x_wrap;
  logic           out_z_wrap, out_y_wrap, out_x_wrap;

  assign wr_en      = cmd_i.accept && !in_item_i.is_padding;
  assign in_z_wrap  = (ZW'(in_z_q) + ZW'(1)) >= eff_z;
  assign in_y_wrap  = (YW'(in_y_q) + YW'(1)) >= eff_y;
  assign in_x_wrap  = (13'(in_x_q) + 13'd1) >= eff_x;
  assign out_z_wrap = (ZW'(out_z_q) + ZW'(1)) >= eff_z;
  assign out_y_wrap = (YW'(out_y_q) + YW'(1)) >= eff_y;
  assign out_x_wrap = (13'(out_x_q) + 13'd1) >= eff_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_x_q   <= '0;
      in_y_q   <= '0;
      in_z_q   <= '0;
      out_x_q  <= '0;
      out_y_q  <= '0;
      out_z_q  <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
    end else if (restart) begin
      in_x_q   <= '0;
      in_y_q   <= '0;
      in_z_q   <= '0;
      out_x_q  <= '0;
      out_y_q  <= '0;
      out_z_q  <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
    end else begin
      if (wr_en) begin
        count_q  <= count_q + CW'(1);
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + AW'(1);
        if (in_z_wrap) begin
          in_z_q <= '0;
          if (in_y_wrap) begin
            in_y_q <= '0;
            in_x_q <= in_x_wrap ? 12'd0 : in_x_q + 12'd1;
          end else begin
            in_y_q <= in_y_q + PYW'(1);
          end
        end else begin
          in_z_q <= in_z_q + PZW'(1);
        end
      end else if (cmd_i.out_load) begin
        count_q <= count_q - CW'(1);
        if (out_z_wrap) begin
          out_z_q <= '0;
          if (out_y_wrap) begin
            out_y_q <= '0;
            out_x_q <= out_x_wrap ? 12'd0 : out_x_q + 12'd1;
          end else begin
            out_y_q <= out_y_q + PYW'(1);
          end
        end else begin
          out_z_q <= out_z_q + PZW'(1);
        end
      end
    end
  end

  // classify the next pending cell
  logic [13:0] ii, jj, kk, xx, yy, zz, gg;
  logic        filt_d, last_d, emit_req;

  always_comb begin
    ii = 14'(out_x_q);
    jj = 14'(out_y_q);
    kk = 14'(out_z_q);
    xx = 14'(eff_x);
    yy = 14'(eff_y);
    zz = 14'(eff_z);
    gg = 14'(g);
    filt_d = (jj >= gg + 14'd1) && (jj + gg + 14'd1 < yy) &&
             (kk >= gg + 14'd1) && (kk + gg + 14'd1 < zz) &&
             (ii >= gg + 14'd1) && (ii + gg < xx) &&
             (periodic_q || ((ii > gg + 14'd1) && (ii + gg + 14'd1 < xx)));
    last_d = (ii == xx - 14'd1) && (jj == yy - 14'd1) && (kk == zz - 14'd1);
    if (in_item_i.is_padding) begin
      emit_req = (in_x_q == '0) && (in_y_q == '0) && (in_z_q == '0) && (count_q != '0);
    end else begin
      emit_req = (count_q >= lag);
    end
  end

  logic [AW-1:0]        base_q;
  logic                 filt_q, last_q;
  logic signed [OW-1:0] base_diff;

  assign base_diff = $signed(OW'(wr_ptr_q)) - $signed(OW'(count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= 1'b0;
      last_q <= 1'b0;
      base_q <= '0;
    end else if (cmd_i.accept) begin
      filt_q <= filt_d;
      last_q <= last_d;
      base_q <= AW'((base_diff < 0) ? base_diff + DepthS : base_diff);
    end
  end

  // stencil address: base plus dx*YZ + dy*Z + dz, wrapped into the ring
  logic signed [OW-1:0] off_x, off_y, off_z, addr_sum, addr_fix;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    case (cmd_i.dx)
      2'd0:    off_x = -$signed(OW'(yz));
      2'd2:    off_x = $signed(OW'(yz));
      default: off_x = '0;
    endcase
    case (cmd_i.dy)
      2'd0:    off_y = -$signed(OW'(eff_z));
      2'd2:    off_y = $signed(OW'(eff_z));
      default: off_y = '0;
    endcase
    case (cmd_i.dz)
      2'd0:    off_z = -OW'(1);
      2'd2:    off_z = OW'(1);
      default: off_z = '0;
    endcase
    addr_sum = $signed(OW'(base_q)) + off_x + off_y + off_z;
    if (addr_sum < 0)            addr_fix = addr_sum + DepthS;
    else if (addr_sum >= DepthS) addr_fix = addr_sum - DepthS;
    else                         addr_fix = addr_sum;
    rd_addr = AW'(addr_fix);
  end

  // ring store
  logic signed [SB-1:0] mem_q [Depth];
  logic signed [SB-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= SB'(in_item_i.sample_in);
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // operand windows of the three blend levels
  logic signed [SB-1:0] l0_q [3];
  logic signed [SB-1:0] l1_q [3];
  logic signed [SB-1:0] l2_q [3];
  logic signed [SB-1:0] op_a, op_b, op_c, res_q, blend;
  logic signed [DW-1:0] d_q;
  logic signed [HW-1:0] dh;
  logic signed [PW-1:0] ph;
  logic [34:0]          pl;
  logic [17:0]          rnd;
  logic signed [RW-1:0] sum;

  always_comb begin
    case (cmd_i.level)
      LVL_Z: begin
        op_a = l0_q[0];
        op_b = l0_q[1];
        op_c = l0_q[2];
      end
      LVL_Y: begin
        op_a = l1_q[0];
        op_b = l1_q[1];
        op_c = l1_q[2];
      end
      default: begin
        op_a = l2_q[0];
        op_b = l2_q[1];
        op_c = l2_q[2];
      end
    endcase
    dh  = $signed(d_q[DW-1:17]);
    ph  = PW'(dh) * PW'($signed({1'b0, s_eff}));
    pl  = 35'(s_eff) * 35'(d_q[16:0]) + 35'd65536;
    rnd = pl[34:17];
    sum = RW'(op_b) + RW'(ph) + RW'($signed({1'b0, rnd}));
    if (sum > SatHi)      blend = SB'(SatHi);
    else if (sum < SatLo) blend = SB'(SatLo);
    else                  blend = SB'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_capture) begin
      l0_q[0] <= l0_q[1];
      l0_q[1] <= l0_q[2];
      l0_q[2] <= rd_q;
      res_q   <= rd_q;
    end
    if (cmd_i.bl_diff) begin
      d_q <= DW'(op_a) + DW'(op_c) - (DW'(op_b) <<< 1);
    end
    if (cmd_i.bl_mix) begin
      case (cmd_i.level)
        LVL_Z: begin
          l1_q[0] <= l1_q[1];
          l1_q[1] <= l1_q[2];
          l1_q[2] <= blend;
        end
        LVL_Y: begin
          l2_q[0] <= l2_q[1];
          l2_q[1] <= l2_q[2];
          l2_q[2] <= blend;
        end
        default: res_q <= blend;
      endcase
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.sample_out   <= 32'(res_q);
      out_item_q.was_filtered <= filt_q;
      out_item_q.grid_last    <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;
  assign sts_o.emit_req  = emit_req;
  assign sts_o.emit_filt = filt_d;
  assign sts_o.filt      = filt_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/grid_3d_binomial_smoother_top.sv =====
// ----------------------------------------------------------------------------
// grid_3d_binomial_smoother_top
// Streaming 3x3x3 separable binomial smoother over a raster-ordered grid.
// ----------------------------------------------------------------------------
// Sequencing: one request at a time; the input is stalled until the sequencer
//   is back in idle. A request that emits nothing is taken in idle; one that
//   emits a passed-through cell makes one store read; one that emits a filtered
//   cell makes 27 reads through the single store read port (address, then data
//   state) and 13 blends in the shared blend unit (difference, then mix state),
//   plus accept and output. The result enters the output register on leaving
//   the output state; a full, stalled output register holds the sequencer and stalls the input.
// Reset: clears positions, pending count and registers to defaults; the ring
//   store is not cleared.
module grid_3d_binomial_smoother_top #(
  parameter int unsigned MAX_Y       = 64,
  parameter int unsigned MAX_Z       = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  g3bs_pkg::in_item_t               in_item_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output g3bs_pkg::out_item_t              out_item_o,
  // register write port
  input  logic                             cfg_we_i,
  input  logic [g3bs_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [g3bs_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import g3bs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: one request at a time, walks the stencil reads and blends
  g3bs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: store, positions, blend unit, output register
  g3bs_dp #(
    .MAX_Y       (MAX_Y),
    .MAX_Z       (MAX_Z),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
